// ----- hw/rtl/mevb_pkg.sv -----
// Shared types and constants for the MIDI event byte encoder.
// Holds the payload structs, action codes, SMF byte constants and controller links.
// No dependencies.
package mevb_pkg;

    localparam int VLQ_MAX_BYTES_DEF = 4;
    localparam int DELTA_W           = 28;

    // Tempo divider: 60000000 fits in 26 bits, one quotient bit per cycle
    localparam int              DIV_STEPS = 26;
    localparam int              DIV_CNT_W = 5;
    localparam logic [25:0]     TEMPO_NUM = 26'd60000000;
    localparam logic [23:0]     TEMPO_MAX = 24'hFFFFFF;

    // Action codes
    localparam logic [2:0] ACT_TEMPO     = 3'd0;
    localparam logic [2:0] ACT_TIME_SIG  = 3'd1;
    localparam logic [2:0] ACT_END_TRACK = 3'd2;
    localparam logic [2:0] ACT_PROGRAM   = 3'd3;
    localparam logic [2:0] ACT_VOLUME    = 3'd4;
    localparam logic [2:0] ACT_NOTE_ON   = 3'd5;
    localparam logic [2:0] ACT_NOTE_OFF  = 3'd6;
    localparam logic [2:0] ACT_UNUSED    = 3'd7;

    // Standard MIDI File byte constants
    localparam logic [7:0] B_ZERO        = 8'h00;
    localparam logic [7:0] B_META        = 8'hFF;
    localparam logic [7:0] B_META_TEMPO  = 8'h51;
    localparam logic [7:0] B_META_TSIG   = 8'h58;
    localparam logic [7:0] B_META_EOT    = 8'h2F;
    localparam logic [7:0] B_LEN_TEMPO   = 8'h03;
    localparam logic [7:0] B_LEN_TSIG    = 8'h04;
    localparam logic [7:0] B_TSIG_CLOCKS = 8'h18;
    localparam logic [7:0] B_TSIG_32NDS  = 8'h08;
    localparam logic [7:0] B_STAT_PROG   = 8'hC0;
    localparam logic [7:0] B_STAT_CTRL   = 8'hB0;
    localparam logic [7:0] B_CC_VOLUME   = 8'h07;
    localparam logic [7:0] B_STAT_NON    = 8'h90;
    localparam logic [7:0] B_STAT_NOFF   = 8'h80;
    localparam logic [7:0] B_VEL_ON      = 8'd100;
    localparam logic [7:0] B_LOW7_MASK   = 8'b01111111;
    localparam logic [7:0] B_CONT_BIT    = 8'b10000000;

    typedef struct packed {
        logic [2:0]  action;
        logic [27:0] delta_ticks;
        logic [3:0]  channel;
        logic [9:0]  tempo_bpm;
        logic [7:0]  beats_per_bar;
        logic [2:0]  beat_unit_log2;
        logic [6:0]  program_number;
        logic [7:0]  volume;
        logic [6:0]  note_number;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic req_is_tempo;
        logic req_is_unused;
        logic div_done;
        logic slot_free;
        logic last;
    } dp_status_t;

endpackage

// ----- hw/rtl/mevb_datapath.sv -----
// Datapath of the MIDI event byte encoder: captured request, serial tempo
// divider, VLQ group select, byte sequencer and output register.
// Depends on mevb_pkg.
module mevb_datapath #(
    parameter int VLQ_MAX_BYTES = mevb_pkg::VLQ_MAX_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mevb_pkg::req_t        req,
    output mevb_pkg::rsp_t        rsp,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  mevb_pkg::ctl_cmd_t    cmd,
    output mevb_pkg::dp_status_t  status
);
    import mevb_pkg::*;

    localparam int DW      = 7 * VLQ_MAX_BYTES;
    localparam int LEN_MAX = (VLQ_MAX_BYTES + 3 > 8) ? VLQ_MAX_BYTES + 3 : 8;
    localparam int IDX_W   = $clog2(LEN_MAX);

    logic [DW-1:0]        delta_sat;
    logic [IDX_W-1:0]     vlq_n;

    logic [2:0]           act_reg;
    logic [3:0]           chan_reg;
    logic [9:0]           bpm_reg;
    logic [7:0]           beats_reg;
    logic [2:0]           unit_reg;
    logic [6:0]           prog_reg;
    logic [7:0]           vol_reg;
    logic [6:0]           note_reg;
    logic [DW-1:0]        delta_reg;
    logic [IDX_W-1:0]     vlq_n_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [25:0]          quo_reg;
    logic [9:0]           rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    rsp_t                 rsp_reg;
    logic                 rsp_valid_reg;

    logic [10:0]          trial;
    logic                 fits;
    logic [9:0]           rem_next;
    logic [23:0]          tempo_val;
    logic [7:0]           fix_seq [8];
    logic [IDX_W-1:0]     fix_last;
    logic                 is_note;
    logic                 in_vlq;
    logic [IDX_W-1:0]     grp_sel;
    logic [IDX_W-1:0]     rel;
    logic [IDX_W-1:0]     note_last;
    logic [6:0]           grp;
    logic [7:0]           byte_sel;
    logic                 last;

    // Saturate the delta to what the VLQ groups can carry
    generate
        if (DW >= DELTA_W) begin : g_delta_wide
            assign delta_sat = DW'(req.delta_ticks);
        end else begin : g_delta_narrow
            assign delta_sat = (|req.delta_ticks[DELTA_W-1:DW]) ? {DW{1'b1}}
                                                                 : req.delta_ticks[DW-1:0];
        end
    endgenerate

    // Number of VLQ bytes: highest nonzero group, at least one
    always_comb
    begin
        vlq_n = IDX_W'(1);
        for (int k = 1; k < VLQ_MAX_BYTES; k++)
        begin
            if (|delta_sat[7*k +: 7])
                vlq_n = IDX_W'(k + 1);
        end
    end

    // One restoring divide step
    assign trial    = {rem_reg, quo_reg[25]};
    assign fits     = trial >= {1'b0, bpm_reg};
    assign rem_next = fits ? 10'(trial - {1'b0, bpm_reg}) : trial[9:0];

    assign tempo_val = (|quo_reg[25:24]) ? TEMPO_MAX : quo_reg[23:0];

    // Fixed-length events
    always_comb
    begin
        for (int k = 0; k < 8; k++)
            fix_seq[k] = B_ZERO;
        fix_last = '0;
        case (act_reg)
            ACT_TEMPO:
            begin
                fix_seq[1] = B_META;
                fix_seq[2] = B_META_TEMPO;
                fix_seq[3] = B_LEN_TEMPO;
                fix_seq[4] = tempo_val[23:16];
                fix_seq[5] = tempo_val[15:8];
                fix_seq[6] = tempo_val[7:0];
                fix_last   = IDX_W'(6);
            end
            ACT_TIME_SIG:
            begin
                fix_seq[1] = B_META;
                fix_seq[2] = B_META_TSIG;
                fix_seq[3] = B_LEN_TSIG;
                fix_seq[4] = beats_reg;
                fix_seq[5] = {5'd0, unit_reg};
                fix_seq[6] = B_TSIG_CLOCKS;
                fix_seq[7] = B_TSIG_32NDS;
                fix_last   = IDX_W'(7);
            end
            ACT_END_TRACK:
            begin
                fix_seq[1] = B_META;
                fix_seq[2] = B_META_EOT;
                fix_last   = IDX_W'(3);
            end
            ACT_PROGRAM:
            begin
                fix_seq[1] = B_STAT_PROG | {4'd0, chan_reg};
                fix_seq[2] = {1'b0, prog_reg};
                fix_last   = IDX_W'(2);
            end
            ACT_VOLUME:
            begin
                fix_seq[1] = B_STAT_CTRL | {4'd0, chan_reg};
                fix_seq[2] = B_CC_VOLUME;
                fix_seq[3] = vol_reg & B_LOW7_MASK;
                fix_last   = IDX_W'(3);
            end
            default:
            begin
                fix_last = '0;
            end
        endcase
    end

    // Note events: VLQ groups most significant first, then status, pitch, velocity
    assign is_note   = (act_reg == ACT_NOTE_ON) || (act_reg == ACT_NOTE_OFF);
    assign in_vlq    = idx_reg < vlq_n_reg;
    assign grp_sel   = vlq_n_reg - IDX_W'(1) - idx_reg;
    assign rel       = idx_reg - vlq_n_reg;
    assign note_last = vlq_n_reg + IDX_W'(2);

    always_comb
    begin
        grp = '0;
        for (int k = 0; k < VLQ_MAX_BYTES; k++)
        begin
            if (IDX_W'(k) == grp_sel)
                grp = delta_reg[7*k +: 7];
        end
    end

    always_comb
    begin
        if (!is_note)
            byte_sel = fix_seq[idx_reg[2:0]];
        else if (in_vlq)
            byte_sel = ((idx_reg != vlq_n_reg - IDX_W'(1)) ? B_CONT_BIT : B_ZERO)
                       | {1'b0, grp};
        else if (rel == '0)
            byte_sel = ((act_reg == ACT_NOTE_ON) ? B_STAT_NON : B_STAT_NOFF)
                       | {4'd0, chan_reg};
        else if (rel == IDX_W'(1))
            byte_sel = {1'b0, note_reg};
        else
            byte_sel = (act_reg == ACT_NOTE_ON) ? B_VEL_ON : B_ZERO;
    end

    assign last = idx_reg == (is_note ? note_last : fix_last);

    // Capture the request, run the divider and register the output byte
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= req.action;
            chan_reg  <= req.channel;
            bpm_reg   <= req.tempo_bpm;
            beats_reg <= req.beats_per_bar;
            unit_reg  <= req.beat_unit_log2;
            prog_reg  <= req.program_number;
            vol_reg   <= req.volume;
            note_reg  <= req.note_number;
            delta_reg <= delta_sat;
            vlq_n_reg <= vlq_n;
            quo_reg   <= TEMPO_NUM;
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[24:0], fits};
            rem_reg <= rem_next;
        end
        if (cmd.emit)
            rsp_reg <= '{out_byte: byte_sel, last_byte: last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            div_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg     <= '0;
                div_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.div_step)
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                if (cmd.emit)
                    idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.emit)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    assign status.req_is_tempo  = req.action == ACT_TEMPO;
    assign status.req_is_unused = req.action == ACT_UNUSED;
    assign status.div_done      = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign status.slot_free     = !rsp_valid_reg || !rsp_stall;
    assign status.last          = last;

endmodule

// ----- hw/rtl/mevb_ctrl.sv -----
// Controller of the MIDI event byte encoder: one-hot state machine that
// sequences request capture, tempo division and byte emission.
// Depends on mevb_pkg.
module mevb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    output mevb_pkg::ctl_cmd_t    cmd,
    input  mevb_pkg::dp_status_t  status
);
    import mevb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.emit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = req_valid;
                if (req_valid)
                begin
                    if (status.req_is_tempo)
                        state_next = ST_DIV;
                    else if (!status.req_is_unused)
                        state_next = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // advance only when the output register can take a byte
                cmd.emit = status.slot_free;
                if (status.slot_free && status.last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign req_stall = state_reg != ST_IDLE;

    a_tempo_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && req_valid && status.req_is_tempo) |=> state_reg == ST_DIV)
        else $error("tempo request did not start the divider");

    a_div_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && status.div_done) |=> state_reg == ST_EMIT)
        else $error("divider finish did not start emission");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.last) |=> (state_reg == ST_IDLE && !req_stall))
        else $error("controller did not return to idle after last byte");

    a_unused_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && req_valid && status.req_is_unused) |=> state_reg == ST_IDLE)
        else $error("unused action code started an event");

endmodule

// ----- hw/rtl/midi_event_byte_encoder_core.sv -----
// A non-tempo item goes from capture straight to byte emission; a tempo item first
// runs the bit-serial divide of 60000000 by the BPM.
// Throughput: one item at a time, one byte per cycle while the output does not stall;
// the next item is taken only after the last byte of the current one is emitted.
// Reset: asynchronous active-low rst_n returns the controller to idle and empties
// the output register; no memories need clearing.
module midi_event_byte_encoder_core #(
    parameter int VLQ_MAX_BYTES = mevb_pkg::VLQ_MAX_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  mevb_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mevb_pkg::rsp_t rsp
);
    import mevb_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    mevb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .status    (status)
    );

    mevb_datapath #(
        .VLQ_MAX_BYTES (VLQ_MAX_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
